// ===== sv/rgb2hsl_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB to HSL converter package
// Shared widths, the stage enable bundle for the pipelined divider and the
// reciprocal constants of the lightness path.
// ----------------------------------------------------------------------------
`default_nettype none

package rgb2hsl_pkg;

	// Dividend, divisor and quotient widths of the shared divider lanes.
	localparam int NUM_W     = 18;
	localparam int DEN_W     = 10;
	localparam int QUO_W     = 9;
	// Quotient bits resolved in each divider stage.
	localparam int STEP_BITS = 3;

	// Lightness is floor((20*sum + 51) / 102), taken as a multiply by a scaled
	// reciprocal of 102. The numerator stays below 10252, for which the product
	// shifted right by LIGHT_SHIFT is exact.
	localparam int                     LIGHT_NUM_W  = 14;
	localparam int                     LIGHT_PROD_W = 2 * LIGHT_NUM_W;
	localparam int                     LIGHT_SHIFT  = 20;
	localparam logic [LIGHT_NUM_W-1:0] LIGHT_RECIP  = 14'd10281;

	// Load enables of the three divider stages.
	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} div_en_t;

endpackage

`default_nettype wire

// ===== sv/rgb2hsl_divider.sv =====
// ----------------------------------------------------------------------------
// RGB to HSL divider lane
// Restoring divider over three register stages, three quotient bits each.
// The quotient must fit in QUO_W bits, i.e. the top dividend bits are below
// the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb2hsl_divider
	import rgb2hsl_pkg::*;
(
	input  wire logic             clk,
	input  wire div_en_t          en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [QUO_W-1:0] quo
);

	// Three restoring steps; returns the new remainder over the quotient bits.
	function automatic logic [DEN_W+STEP_BITS-1:0] div_step(
		input logic [DEN_W-1:0]     rem_in,
		input logic [STEP_BITS-1:0] bits,
		input logic [DEN_W-1:0]     dvs
	);
		logic [DEN_W:0]       t;
		logic [DEN_W-1:0]     r;
		logic [STEP_BITS-1:0] q;
		r = rem_in;
		q = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			t = {r, bits[STEP_BITS-1-i]};
			if (t >= {1'b0, dvs}) begin
				t = t - {1'b0, dvs};
				q[STEP_BITS-1-i] = 1'b1;
			end
			r = t[DEN_W-1:0];
		end
		return {r, q};
	endfunction

	logic [DEN_W+STEP_BITS-1:0] step3, step4, step5;

	logic [DEN_W-1:0]       rem_s3, rem_s4;
	logic [DEN_W-1:0]       den_s3, den_s4;
	logic [2*STEP_BITS-1:0] low_s3;
	logic [STEP_BITS-1:0]   low_s4;
	logic [STEP_BITS-1:0]   quo_s3;
	logic [2*STEP_BITS-1:0] quo_s4;
	logic [QUO_W-1:0]       quo_s5;

	// Each stage resolves the next three dividend bits.
	always_comb begin
		step3 = div_step({1'b0, num[NUM_W-1:QUO_W]}, num[QUO_W-1:2*STEP_BITS], den);
		step4 = div_step(rem_s3, low_s3[2*STEP_BITS-1:STEP_BITS], den_s3);
		step5 = div_step(rem_s4, low_s4, den_s4);
	end

	// Stage registers move only when their stage is allowed to load.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			rem_s3 <= step3[DEN_W+STEP_BITS-1:STEP_BITS];
			quo_s3 <= step3[STEP_BITS-1:0];
			low_s3 <= num[2*STEP_BITS-1:0];
			den_s3 <= den;
		end
		if (en.s4) begin
			rem_s4 <= step4[DEN_W+STEP_BITS-1:STEP_BITS];
			quo_s4 <= {quo_s3, step4[STEP_BITS-1:0]};
			low_s4 <= low_s3[STEP_BITS-1:0];
			den_s4 <= den_s3;
		end
		if (en.s5) begin
			quo_s5 <= {quo_s4, step5[STEP_BITS-1:0]};
		end
	end

	assign quo = quo_s5;

endmodule

`default_nettype wire

// ===== sv/rgb_to_hsl_converter_top.sv =====
// ----------------------------------------------------------------------------
// RGB to HSL converter
// Converts one 8-bit RGB pixel word into hue in degrees and saturation and
// lightness in percent, each rounded to nearest with ties upward.
//
// Usage:
// - The input channel (in_valid, in_stall, red, green, blue) takes one pixel
//   word per cycle; a word is taken when in_valid is high and in_stall low.
// - The output channel (out_valid, out_stall, hue, saturation, lightness)
//   delivers one result word per pixel, in order.
// - Stages: the first finds the channel extremes, the second the numerators
//   and divisors, and the third to fifth form the hue and saturation divider
//   lanes, which resolve three quotient bits per stage. Lightness is a
//   reciprocal multiply in the third stage, carried along to the fifth.
// - The five-stage pipeline takes one pixel per cycle while in_stall is low.
// - When the receiver stalls, the last stage holds its word; bubbles in the
//   earlier stages still fill, and in_stall rises only once every stage holds
//   a word.
// - Reset clears all valid bits; no result is presented until a new pixel
//   has passed through.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsl_converter_top
	import rgb2hsl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [8:0]      hue,
	output logic [6:0]      saturation,
	output logic [6:0]      lightness
);

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// Stage valid bits and load enables.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic ready1, ready2, ready3, ready4, ready5;
	div_en_t div_en;

	// First stage: extremes and sector.
	logic [7:0]        mx, mn;
	sector_t           sector;
	logic signed [8:0] diff;

	logic [7:0]        d_s1;
	logic [8:0]        sum_s1;
	sector_t           sector_s1;
	logic signed [8:0] diff_s1;

	// Second stage: numerators and divisors.
	logic signed [18:0]     d_ext, diff_ext, hnum;
	logic [8:0]             sden_half;
	logic [NUM_W-1:0]       hnum_div, snum_div;
	logic [LIGHT_NUM_W-1:0] lnum_div;
	logic [DEN_W-1:0]       hden_div, sden_div;

	logic [NUM_W-1:0]       hnum_s2, snum_s2;
	logic [LIGHT_NUM_W-1:0] lnum_s2;
	logic [DEN_W-1:0]       hden_s2, sden_s2;
	logic                   grey_s2, grey_s3, grey_s4, grey_s5;

	// Lightness path from the third stage on.
	logic [LIGHT_PROD_W-1:0] light_prod;
	logic [6:0]              light_s3, light_s4, light_s5;

	logic [QUO_W-1:0] hue_quo, sat_quo;

	// A stage loads when it is empty or the next one loads.
	always_comb begin
		ready5    = !valid_s5 || !out_stall;
		ready4    = !valid_s4 || ready5;
		ready3    = !valid_s3 || ready4;
		ready2    = !valid_s2 || ready3;
		ready1    = !valid_s1 || ready2;
		in_stall  = !ready1;
		div_en.s3 = ready3;
		div_en.s4 = ready4;
		div_en.s5 = ready5;
	end

	// Largest channel wins ties in the order red, green, blue.
	always_comb begin
		if (red >= green && red >= blue) begin
			sector = SEC_RED;
			mx     = red;
			diff   = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (green >= blue) begin
			sector = SEC_GREEN;
			mx     = green;
			diff   = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			sector = SEC_BLUE;
			mx     = blue;
			diff   = $signed({1'b0, red}) - $signed({1'b0, green});
		end
		mn = red;
		if (green < mn) begin
			mn = green;
		end
		if (blue < mn) begin
			mn = blue;
		end
	end

	// Numerators are doubled and offset by the divisor for round-half-up.
	always_comb begin
		d_ext    = $signed({11'b0, d_s1});
		diff_ext = {{10{diff_s1[8]}}, diff_s1};
		case (sector_s1)
			SEC_RED:   hnum = diff_ext * 19'sd60;
			SEC_GREEN: hnum = d_ext * 19'sd120 + diff_ext * 19'sd60;
			SEC_BLUE:  hnum = d_ext * 19'sd240 + diff_ext * 19'sd60;
			default:   hnum = '0;
		endcase
		if (sector_s1 == SEC_RED && hnum < 0) begin
			hnum = hnum + d_ext * 19'sd360;
		end
		hnum_div = {hnum[16:0], 1'b0} + {10'b0, d_s1};
		hden_div = {1'b0, d_s1, 1'b0};

		if (sum_s1 < 9'd255) begin
			sden_half = sum_s1;
		end else begin
			sden_half = 9'd510 - sum_s1;
		end
		snum_div = NUM_W'(d_s1) * NUM_W'(200) + NUM_W'(sden_half);
		sden_div = {sden_half, 1'b0};

		// Rounded sum*100/510 reduces to floor((20*sum + 51) / 102).
		lnum_div = LIGHT_NUM_W'(sum_s1) * LIGHT_NUM_W'(20) + LIGHT_NUM_W'(51);
	end

	// Division of the lightness numerator by 102 through its reciprocal.
	always_comb begin
		light_prod = LIGHT_PROD_W'(lnum_s2) * LIGHT_PROD_W'(LIGHT_RECIP);
	end

	// Valid bits of every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready1) begin
				valid_s1 <= in_valid;
			end
			if (ready2) begin
				valid_s2 <= valid_s1;
			end
			if (ready3) begin
				valid_s3 <= valid_s2;
			end
			if (ready4) begin
				valid_s4 <= valid_s3;
			end
			if (ready5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// Payload registers of the first two stages, the grey flag and lightness.
	always_ff @(posedge clk) begin
		if (ready1) begin
			d_s1      <= mx - mn;
			sum_s1    <= {1'b0, mx} + {1'b0, mn};
			sector_s1 <= sector;
			diff_s1   <= diff;
		end
		if (ready2) begin
			hnum_s2 <= hnum_div;
			hden_s2 <= hden_div;
			snum_s2 <= snum_div;
			sden_s2 <= sden_div;
			lnum_s2 <= lnum_div;
			grey_s2 <= (d_s1 == 8'd0);
		end
		if (ready3) begin
			grey_s3  <= grey_s2;
			light_s3 <= light_prod[LIGHT_SHIFT +: 7];
		end
		if (ready4) begin
			grey_s4  <= grey_s3;
			light_s4 <= light_s3;
		end
		if (ready5) begin
			grey_s5  <= grey_s4;
			light_s5 <= light_s4;
		end
	end

	// Two divider lanes run side by side.
	rgb2hsl_divider u_hue_div (
		.clk (clk),
		.en  (div_en),
		.num (hnum_s2),
		.den (hden_s2),
		.quo (hue_quo)
	);

	rgb2hsl_divider u_sat_div (
		.clk (clk),
		.en  (div_en),
		.num (snum_s2),
		.den (sden_s2),
		.quo (sat_quo)
	);

	// A grey pixel has zero hue and saturation.
	always_comb begin
		out_valid  = valid_s5;
		hue        = grey_s5 ? 9'd0 : hue_quo;
		saturation = grey_s5 ? 7'd0 : sat_quo[6:0];
		lightness  = light_s5;
	end

endmodule

`default_nettype wire

// ===== test/rgb_to_hsl_converter_top_test.sv =====
// ----------------------------------------------------------------------------
// RGB to HSL converter testbench
// Streams directed and random pixel words through the converter with random
// gaps on the input and random stalls on the output. Each accepted pixel is
// converted by an integer model of the HSL math. Each result word is checked
// field by field, in order, against the oldest pending prediction.
// ----------------------------------------------------------------------------

module rgb_to_hsl_converter_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_PIXELS = 1630;
	localparam int IDLE_LIMIT    = 3000;
	localparam int HOLD_CYCLES   = 200;
	localparam int DRAIN_CYCLES  = 10;

	// One converted pixel as the block reports it.
	typedef struct packed {
		logic [8:0] hue;
		logic [6:0] saturation;
		logic [6:0] lightness;
	} hsl_word_t;

	// Predicts the HSL word of each accepted pixel and checks the results in order.
	class hsl_tracker;
		hsl_word_t expected_hsl[$];
		int        errors;

		function new();
			errors = 0;
		endfunction

		// Rounds num/den to nearest, with ties going up.
		static function int round_half_up(int num, int den);
			return (2 * num + den) / (2 * den);
		endfunction

		static function hsl_word_t hsl_of_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			int        mx;
			int        mn;
			int        d;
			int        sum;
			int        hnum;
			int        den;
			hsl_word_t w;
			mx = r;
			mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			d   = mx - mn;
			sum = mx + mn;
			w   = '0;
			w.lightness = 7'(round_half_up(sum * 100, 510));
			// A grey pixel has neither hue nor saturation.
			if (d != 0) begin
				den = (sum < 255) ? sum : 510 - sum;
				w.saturation = 7'(round_half_up(d * 100, den));
				// Red wins ties for the largest channel, then green.
				if (int'(r) == mx) begin
					hnum = 60 * (int'(g) - int'(b));
					if (hnum < 0) hnum += 360 * d;
				end else if (int'(g) == mx) begin
					hnum = 120 * d + 60 * (int'(b) - int'(r));
				end else begin
					hnum = 240 * d + 60 * (int'(r) - int'(g));
				end
				w.hue = 9'(round_half_up(hnum, d));
			end
			return w;
		endfunction

		function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			expected_hsl.push_back(hsl_of_pixel(r, g, b));
		endfunction

		function void check_result(logic [8:0] h, logic [6:0] s, logic [6:0] l);
			hsl_word_t want;
			if (expected_hsl.size() == 0) begin
				$error("result word with no pixel pending: hue %0d sat %0d light %0d", h, s, l);
				errors++;
				return;
			end
			want = expected_hsl.pop_front();
			if (h !== want.hue) begin
				$error("hue: expected %0d, actual %0d", want.hue, h);
				errors++;
			end
			if (s !== want.saturation) begin
				$error("saturation: expected %0d, actual %0d", want.saturation, s);
				errors++;
			end
			if (l !== want.lightness) begin
				$error("lightness: expected %0d, actual %0d", want.lightness, l);
				errors++;
			end
		endfunction

		function int pending();
			return expected_hsl.size();
		endfunction
	endclass

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_stall;
	logic [7:0] red        = 8'd0;
	logic [7:0] green      = 8'd0;
	logic [7:0] blue       = 8'd0;
	logic       out_valid;
	logic       out_stall  = 1'b0;
	logic [8:0] hue;
	logic [6:0] saturation;
	logic [6:0] lightness;

	hsl_tracker tracker = new();

	// The first two are shared by sender and receiver for the long output hold-off.
	bit         hold_request     = 1'b0;
	int         hold_cycles_left = 0;
	int         burst_left       = 0;
	int         idle_cycles      = 0;

	// Corner pixels, packed as red, green, blue.
	logic [23:0] directed_px [22] = '{
		24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
		24'h00FFFF, 24'hFF00FF, 24'h808080, 24'hFF0001, 24'hC8C832, 24'h32C8C8,
		24'hC832C8, 24'hFE0000, 24'h7F0000, 24'h010000, 24'hFFFEFE, 24'h000101,
		24'h7F8080, 24'h7F7F80, 24'hFF00FE, 24'h80FF80
	};

	rgb_to_hsl_converter_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hue        (hue),
		.saturation (saturation),
		.lightness  (lightness)
	);

	always #10 clk = ~clk;

	// Offers one pixel word and waits until the block takes it.
	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		red      <= r;
		green    <= g;
		blue     <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		tracker.note_pixel(r, g, b);
	endtask

	// Idles the input for a random number of cycles, mostly none or a few.
	task automatic pause_sender();
		int n;
		int sel;
		sel = $urandom_range(0, 99);
		n   = 0;
		if (burst_left > 0) begin
			burst_left--;
		end else if (hold_cycles_left == 0) begin
			if (sel < 2)
				burst_left = $urandom_range(20, 60);
			else if (sel < 60)
				n = 0;
			else if (sel < 90)
				n = $urandom_range(1, 3);
			else if (sel < 98)
				n = $urandom_range(4, 10);
			else
				n = $urandom_range(20, 40);
		end
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Receiver: checks accepted result words and drives random stall runs.
	initial begin
		int run_left;
		bit stalling;
		run_left = 0;
		stalling = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				tracker.check_result(hue, saturation, lightness);
			if (hold_request) begin
				hold_request     = 1'b0;
				hold_cycles_left = HOLD_CYCLES;
			end
			if (hold_cycles_left > 0) begin
				hold_cycles_left--;
				out_stall <= 1'b1;
			end else begin
				if (run_left == 0) begin
					if ($urandom_range(0, 9) < 3) begin
						stalling = 1'b1;
						run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
							: $urandom_range(1, 3);
					end else begin
						stalling = 1'b0;
						run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
							: $urandom_range(1, 8);
					end
				end
				run_left--;
				out_stall <= stalling;
			end
		end
	end

	// Watchdog: ends the run when no word moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Stimulus: corner pixels first, then a mix of random pixel classes.
	initial begin
		logic [7:0] px [3];
		int         base;
		int         k;
		int         v;
		int         m;
		int         ch;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_px[i]) begin
			send_pixel(directed_px[i][23:16], directed_px[i][15:8], directed_px[i][7:0]);
			pause_sender();
		end

		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			// Hold the output off for a long stretch so the pipeline fills.
			if (i == 500 || i == 1200)
				hold_request = 1'b1;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					foreach (px[c]) px[c] = 8'($urandom_range(0, 255));
				end
				4: begin
					// Grey pixel.
					px[0] = 8'($urandom_range(0, 255));
					px[1] = px[0];
					px[2] = px[0];
				end
				5: begin
					// Two channels tie for the largest value.
					v = $urandom_range(0, 255);
					m = $urandom_range(0, v);
					k = $urandom_range(0, 2);
					foreach (px[c]) px[c] = 8'(m);
					px[k]           = 8'(v);
					px[(k + 1) % 3] = 8'(v);
				end
				6: begin
					// Red largest with blue at or just above green, hue near a full turn.
					px[0] = 8'($urandom_range(128, 255));
					px[1] = 8'($urandom_range(0, 3));
					px[2] = px[1] + 8'($urandom_range(0, 2));
				end
				default: begin
					// Nearly grey pixel with small channel differences.
					base = $urandom_range(0, 255);
					foreach (px[c]) begin
						ch = base + $urandom_range(0, 6) - 3;
						if (ch < 0) ch = 0;
						if (ch > 255) ch = 255;
						px[c] = 8'(ch);
					end
				end
			endcase
			send_pixel(px[0], px[1], px[2]);
			pause_sender();
		end
		in_valid <= 1'b0;

		// Drain: wait for every pending result, then a few more cycles.
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
